// File: hdl/assert_macros.svh
// Assertion helpers for the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked once reset is released.
`define HCCL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked once reset is released.
`define HCCL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/hccl_pkg.sv
package hccl_pkg;

    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 2;
    localparam int CACHE_BITS_W = 4;
    localparam int BLOCK_W_W    = 13;
    localparam int IMAGE_W_W    = 13;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CACHE_BITS  = 2'd0,
        CFG_BLOCK_WIDTH = 2'd1,
        CFG_IMAGE_WIDTH = 2'd2
    } cfg_index_t;

    localparam logic [CACHE_BITS_W-1:0] RESET_CACHE_BITS  = 4'd10;
    localparam logic [BLOCK_W_W-1:0]    RESET_BLOCK_WIDTH = 13'd4096;
    localparam logic [IMAGE_W_W-1:0]    RESET_IMAGE_WIDTH = 13'd1024;

    localparam logic [31:0] HASH_MUL = 32'h1e35a7bd;
    localparam int          NUM_PRELOAD = 8;

    // Low 32 bits of the hash product.
    function automatic logic [31:0] hash_prod(input logic [31:0] px);
        return px * HASH_MUL;
    endfunction

    // Default colours: black, white, red, green, blue, yellow, magenta, cyan.
    localparam logic [31:0] PRELOAD_COLOURS [NUM_PRELOAD] = '{
        32'h000000FF, 32'hFFFFFFFF, 32'hFF0000FF, 32'h00FF00FF,
        32'h0000FFFF, 32'hFFFF00FF, 32'hFF00FFFF, 32'h00FFFFFF
    };

    localparam logic [31:0] PRELOAD_PRODS [NUM_PRELOAD] = '{
        hash_prod(32'h000000FF), hash_prod(32'hFFFFFFFF),
        hash_prod(32'hFF0000FF), hash_prod(32'h00FF00FF),
        hash_prod(32'h0000FFFF), hash_prod(32'hFFFF00FF),
        hash_prod(32'hFF00FFFF), hash_prod(32'h00FFFFFF)
    };

endpackage

// File: hdl/hccl_fifo.sv
module hccl_fifo #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             empty,
    output logic             full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_data = entry_reg[rd_ptr_reg];
    assign empty     = (count_reg == '0);
    assign full      = (count_reg == (PW+1)'(DEPTH));

endmodule

// File: hdl/hccl_front.sv
module hccl_front #(
    parameter int MAX_CACHE_BITS = 10,
    parameter int MAX_BLOCKS     = 16,
    parameter int MAX_WIDTH      = 4096
) (
    input  logic clk,
    input  logic rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    input  logic [7:0] alpha,
    input  logic       start_of_image,
    input  logic [$clog2(MAX_CACHE_BITS+1)-1:0] eff_cache_bits,
    input  logic [((($clog2(MAX_WIDTH+1)) > hccl_pkg::IMAGE_W_W) ?
                   $clog2(MAX_WIDTH+1) : hccl_pkg::IMAGE_W_W)-1:0] eff_image_width,
    input  logic [((($clog2(MAX_WIDTH+1)) > hccl_pkg::IMAGE_W_W) ?
                   $clog2(MAX_WIDTH+1) : hccl_pkg::IMAGE_W_W)-1:0] eff_block_width,
    input  logic clear_busy,
    output logic q_push,
    output logic [32 + MAX_CACHE_BITS + ((MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1):0] q_data,
    input  logic q_full
);

    import hccl_pkg::*;

    localparam int BW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int IWW = $clog2(MAX_WIDTH + 1);
    localparam int XW  = (IWW > IMAGE_W_W) ? IWW : IMAGE_W_W;

    logic [IWW-1:0] col_reg, col_next;
    logic [IWW-1:0] cib_reg, cib_next;
    logic [BW-1:0]  blk_reg, blk_next;

    logic           stage_valid_reg, stage_valid_next;
    logic [31:0]    stage_px_reg;
    logic [31:0]    stage_prod_reg;
    logic [BW-1:0]  stage_blk_reg;
    logic           stage_start_reg;

    logic [31:0]    px;
    logic [IWW-1:0] col_base, cib_base, col_inc, cib_inc;
    logic [BW-1:0]  blk_base;
    logic           accept;
    logic [31:0]    shifted;
    logic [MAX_CACHE_BITS-1:0] slot;

    assign px       = {red, green, blue, alpha};
    assign in_stall = clear_busy || (stage_valid_reg && q_full);
    assign accept   = in_valid && !in_stall;
    assign q_push   = stage_valid_reg && !q_full;

    // Column tracking; a start word resets position before its own pixel.
    always_comb
    begin
        col_base = start_of_image ? '0 : col_reg;
        cib_base = start_of_image ? '0 : cib_reg;
        blk_base = start_of_image ? '0 : blk_reg;
        col_inc  = col_base + 1'b1;
        cib_inc  = cib_base + 1'b1;
        col_next = col_reg;
        cib_next = cib_reg;
        blk_next = blk_reg;
        if (accept)
        begin
            if (XW'(col_inc) >= eff_image_width)
            begin
                col_next = '0;
                cib_next = '0;
                blk_next = '0;
            end
            else if (XW'(cib_inc) >= eff_block_width)
            begin
                col_next = col_inc;
                cib_next = '0;
                blk_next = (blk_base < BW'(MAX_BLOCKS - 1)) ? blk_base + 1'b1 : blk_base;
            end
            else
            begin
                col_next = col_inc;
                cib_next = cib_inc;
                blk_next = blk_base;
            end
        end
        stage_valid_next = accept ? 1'b1 : (q_push ? 1'b0 : stage_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg         <= '0;
            cib_reg         <= '0;
            blk_reg         <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg         <= col_next;
            cib_reg         <= cib_next;
            blk_reg         <= blk_next;
            stage_valid_reg <= stage_valid_next;
        end
    end

    // Hash product registered before the slot select.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_px_reg    <= px;
            stage_prod_reg  <= hash_prod(px);
            stage_blk_reg   <= blk_base;
            stage_start_reg <= start_of_image;
        end
    end

    assign shifted = stage_prod_reg >> (6'd32 - 6'(eff_cache_bits));
    assign slot    = shifted[MAX_CACHE_BITS-1:0];
    assign q_data  = {stage_start_reg, stage_blk_reg, slot, stage_px_reg};

endmodule

// File: hdl/hccl_back.sv
module hccl_back #(
    parameter int MAX_CACHE_BITS = 10,
    parameter int MAX_BLOCKS     = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic [$clog2(MAX_CACHE_BITS+1)-1:0] eff_cache_bits,
    input  logic [32 + MAX_CACHE_BITS + ((MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1):0] q_data,
    input  logic q_empty,
    output logic q_pop,
    output logic clear_busy,
    output logic out_valid,
    input  logic out_stall,
    output logic hit,
    output logic [MAX_CACHE_BITS-1:0] slot_index,
    output logic [((MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1)-1:0] block_number,
    output logic [31:0] hits_total,
    output logic [31:0] slot_hit_count
);

    import hccl_pkg::*;

    localparam int BW          = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CBW         = $clog2(MAX_CACHE_BITS + 1);
    localparam int MCB         = MAX_CACHE_BITS;
    localparam int STORE_DEPTH = MAX_BLOCKS << MAX_CACHE_BITS;
    localparam int SLOT_DEPTH  = 1 << MAX_CACHE_BITS;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam int PRE_CB      = (int'(RESET_CACHE_BITS) > MAX_CACHE_BITS) ?
                                 MAX_CACHE_BITS : int'(RESET_CACHE_BITS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_PRELOAD,
        ST_IDLE,
        ST_READ,
        ST_UPDATE
    } state_t;

    state_t state_reg;

    logic [31:0] colour_mem [STORE_DEPTH];
    logic [31:0] count_mem  [SLOT_DEPTH];
    logic [31:0] rd_colour_reg;
    logic [31:0] rd_count_reg;

    logic [AW-1:0]  clr_idx_reg;
    logic [BW-1:0]  pre_blk_reg;
    logic [2:0]     pre_col_reg;
    logic [CBW-1:0] pre_cb_reg;
    logic           pending_reg;
    logic [31:0]    total_reg;

    logic [31:0]    item_px_reg;
    logic [MCB-1:0] item_slot_reg;
    logic [BW-1:0]  item_blk_reg;

    logic           out_valid_reg;
    logic           out_hit_reg;
    logic [MCB-1:0] out_slot_reg;
    logic [BW-1:0]  out_blk_reg;
    logic [31:0]    out_total_reg;
    logic [31:0]    out_count_reg;

    logic [31:0]    head_px;
    logic [MCB-1:0] head_slot;
    logic [BW-1:0]  head_blk;
    logic           head_start;

    logic [AW-1:0]  rd_addr;
    logic [MCB-1:0] rd_slot;
    logic           col_we;
    logic [AW-1:0]  col_waddr;
    logic [31:0]    col_wdata;
    logic           cnt_we;
    logic [MCB-1:0] cnt_waddr;
    logic [31:0]    cnt_wdata;

    logic [31:0]    pre_shifted;
    logic [MCB-1:0] pre_slot;
    logic           is_hit;
    logic [31:0]    count_new;
    logic [31:0]    total_new;
    logic           out_free;
    logic           pre_last;

    assign head_px    = q_data[31:0];
    assign head_slot  = q_data[32 +: MCB];
    assign head_blk   = q_data[32 + MCB +: BW];
    assign head_start = q_data[32 + MCB + BW];

    assign pre_shifted = PRELOAD_PRODS[pre_col_reg] >> (6'd32 - 6'(pre_cb_reg));
    assign pre_slot    = pre_shifted[MCB-1:0];
    assign pre_last    = (pre_blk_reg == BW'(MAX_BLOCKS - 1)) && (pre_col_reg == 3'd7);

    assign is_hit    = (rd_colour_reg == item_px_reg);
    assign count_new = (is_hit && (rd_count_reg != '1)) ? rd_count_reg + 1'b1 : rd_count_reg;
    assign total_new = (is_hit && (total_reg != '1)) ? total_reg + 1'b1 : total_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign q_pop      = (state_reg == ST_IDLE) && !q_empty;
    assign clear_busy = (state_reg == ST_CLEAR) || (state_reg == ST_PRELOAD);

    // Read from the queue head while idle, else from the held word.
    assign rd_slot = (state_reg == ST_IDLE) ? head_slot : item_slot_reg;
    assign rd_addr = (state_reg == ST_IDLE) ? AW'({head_blk, head_slot})
                                            : AW'({item_blk_reg, item_slot_reg});

    always_comb
    begin
        col_we    = 1'b0;
        col_waddr = clr_idx_reg;
        col_wdata = '0;
        cnt_we    = 1'b0;
        cnt_waddr = clr_idx_reg[MCB-1:0];
        cnt_wdata = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                col_we = 1'b1;
                if ((AW+1)'(clr_idx_reg) < (AW+1)'(SLOT_DEPTH))
                begin
                    cnt_we = 1'b1;
                end
            end
            ST_PRELOAD:
            begin
                col_we    = 1'b1;
                col_waddr = AW'({pre_blk_reg, pre_slot});
                col_wdata = PRELOAD_COLOURS[pre_col_reg];
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    col_we    = !is_hit;
                    col_waddr = AW'({item_blk_reg, item_slot_reg});
                    col_wdata = item_px_reg;
                    cnt_we    = is_hit;
                    cnt_waddr = item_slot_reg;
                    cnt_wdata = count_new;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (col_we)
        begin
            colour_mem[col_waddr] <= col_wdata;
        end
        rd_colour_reg <= colour_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            count_mem[cnt_waddr] <= cnt_wdata;
        end
        rd_count_reg <= count_mem[rd_slot];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            pre_blk_reg   <= '0;
            pre_col_reg   <= '0;
            pre_cb_reg    <= CBW'(PRE_CB);
            pending_reg   <= 1'b0;
            total_reg     <= '0;
            item_px_reg   <= '0;
            item_slot_reg <= '0;
            item_blk_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_hit_reg   <= 1'b0;
            out_slot_reg  <= '0;
            out_blk_reg   <= '0;
            out_total_reg <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if (clr_idx_reg == AW'(STORE_DEPTH - 1))
                    begin
                        clr_idx_reg <= '0;
                        pre_blk_reg <= '0;
                        pre_col_reg <= '0;
                        state_reg   <= ST_PRELOAD;
                    end
                end
                ST_PRELOAD:
                begin
                    pre_col_reg <= pre_col_reg + 1'b1;
                    if (pre_col_reg == 3'd7)
                    begin
                        pre_blk_reg <= pre_blk_reg + 1'b1;
                    end
                    if (pre_last)
                    begin
                        pre_blk_reg <= '0;
                        state_reg   <= pending_reg ? ST_READ : ST_IDLE;
                        pending_reg <= 1'b0;
                    end
                end
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        item_px_reg   <= head_px;
                        item_slot_reg <= head_slot;
                        item_blk_reg  <= head_blk;
                        if (head_start)
                        begin
                            pending_reg <= 1'b1;
                            total_reg   <= '0;
                            pre_cb_reg  <= eff_cache_bits;
                            clr_idx_reg <= '0;
                            state_reg   <= ST_CLEAR;
                        end
                        else
                        begin
                            state_reg <= ST_UPDATE;
                        end
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE:
                begin
                    if (out_free)
                    begin
                        total_reg     <= total_new;
                        out_valid_reg <= 1'b1;
                        out_hit_reg   <= is_hit;
                        out_slot_reg  <= item_slot_reg;
                        out_blk_reg   <= item_blk_reg;
                        out_total_reg <= total_new;
                        out_count_reg <= count_new;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign hit            = out_hit_reg;
    assign slot_index     = out_slot_reg;
    assign block_number   = out_blk_reg;
    assign hits_total     = out_total_reg;
    assign slot_hit_count = out_count_reg;

endmodule

// File: hdl/hashed_colour_cache_lookup.sv
// An accepted pixel word passes the front stage register, the queue, the colour memory
// read register and the output register. The back takes one pixel at a time, popping
// only while idle; a start-of-image word first runs the clearing pass and preload.
// Reset (rst_n low, async): registers take reset values, then a clearing pass
// zeroes and preloads the caches; no pixel is taken during it, configuration writes are.
module hashed_colour_cache_lookup #(
    parameter int MAX_CACHE_BITS = 10,
    parameter int MAX_BLOCKS     = 16,
    parameter int MAX_WIDTH      = 4096
) (
    input  logic clk,
    input  logic rst_n,
    // configuration write port
    input  logic                                  cfg_write_enable,
    input  logic [hccl_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [hccl_pkg::CFG_DATA_W-1:0]       cfg_data,
    // pixel input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    input  logic [7:0] alpha,
    input  logic       start_of_image,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        hit,
    output logic [MAX_CACHE_BITS-1:0] slot_index,
    output logic [((MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1)-1:0] block_number,
    output logic [31:0] hits_total,
    output logic [31:0] slot_hit_count
);

    `include "assert_macros.svh"

    import hccl_pkg::*;

    localparam int BW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CBW  = $clog2(MAX_CACHE_BITS + 1);
    localparam int CBX  = (CBW > CACHE_BITS_W) ? CBW : CACHE_BITS_W;
    localparam int IWW  = $clog2(MAX_WIDTH + 1);
    localparam int XW   = (IWW > IMAGE_W_W) ? IWW : IMAGE_W_W;
    localparam int QW   = 32 + MAX_CACHE_BITS + BW + 1;

    // Configuration registers, to be written only while the block is idle; not enforced.
    logic [CACHE_BITS_W-1:0] cache_bits_reg;
    logic [BLOCK_W_W-1:0]    block_width_reg;
    logic [IMAGE_W_W-1:0]    image_width_reg;

    logic [CBX-1:0] cb_ext, cb_clamped;
    logic [CBW-1:0] eff_cache_bits;
    logic [XW-1:0]  iw_ext, eff_image_width, eff_block_width;

    logic          q_push, q_pop, q_empty, q_full, clear_busy;
    logic [QW-1:0] q_push_data, q_head_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cache_bits_reg  <= RESET_CACHE_BITS;
            block_width_reg <= RESET_BLOCK_WIDTH;
            image_width_reg <= RESET_IMAGE_WIDTH;
        end
        else if (cfg_write_enable)
        begin
            case (cfg_index)
                CFG_CACHE_BITS:  cache_bits_reg  <= cfg_data[CACHE_BITS_W-1:0];
                CFG_BLOCK_WIDTH: block_width_reg <= cfg_data[BLOCK_W_W-1:0];
                CFG_IMAGE_WIDTH: image_width_reg <= cfg_data[IMAGE_W_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Effective settings: cache bits clamped to 1..MAX_CACHE_BITS, image width
    // to 1..MAX_WIDTH, block width zero means a single block per row.
    always_comb
    begin
        cb_ext = CBX'(cache_bits_reg);
        if (cb_ext == '0)
        begin
            cb_clamped = CBX'(1);
        end
        else if (cb_ext > CBX'(MAX_CACHE_BITS))
        begin
            cb_clamped = CBX'(MAX_CACHE_BITS);
        end
        else
        begin
            cb_clamped = cb_ext;
        end
        eff_cache_bits = cb_clamped[CBW-1:0];

        iw_ext = XW'(image_width_reg);
        if (iw_ext == '0)
        begin
            eff_image_width = XW'(1);
        end
        else if (iw_ext > XW'(MAX_WIDTH))
        begin
            eff_image_width = XW'(MAX_WIDTH);
        end
        else
        begin
            eff_image_width = iw_ext;
        end
        eff_block_width = (block_width_reg == '0) ? eff_image_width : XW'(block_width_reg);
    end

    // Front: column/block tracking and hash, one word per cycle into a non-full queue.
    hccl_front #(
        .MAX_CACHE_BITS (MAX_CACHE_BITS),
        .MAX_BLOCKS     (MAX_BLOCKS),
        .MAX_WIDTH      (MAX_WIDTH)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .red             (red),
        .green           (green),
        .blue            (blue),
        .alpha           (alpha),
        .start_of_image  (start_of_image),
        .eff_cache_bits  (eff_cache_bits),
        .eff_image_width (eff_image_width),
        .eff_block_width (eff_block_width),
        .clear_busy      (clear_busy),
        .q_push          (q_push),
        .q_data          (q_push_data),
        .q_full          (q_full)
    );

    // Short queue lets the front keep taking pixels while the back is busy.
    hccl_fifo #(
        .WIDTH (QW),
        .DEPTH (4)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .head_data (q_head_data),
        .empty     (q_empty),
        .full      (q_full)
    );

    // Back: cache memories, clear/preload sequencer, lookup and update.
    hccl_back #(
        .MAX_CACHE_BITS (MAX_CACHE_BITS),
        .MAX_BLOCKS     (MAX_BLOCKS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .eff_cache_bits (eff_cache_bits),
        .q_data         (q_head_data),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .clear_busy     (clear_busy),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hit            (hit),
        .slot_index     (slot_index),
        .block_number   (block_number),
        .hits_total     (hits_total),
        .slot_hit_count (slot_hit_count)
    );

    `HCCL_ASSERT_SAME(a_no_accept_in_clear, in_valid && !in_stall, !clear_busy, "pixel taken during clear")
    `HCCL_ASSERT_SAME(a_no_push_full, q_push, !q_full, "queue overflow")
    `HCCL_ASSERT_SAME(a_no_pop_empty, q_pop, !q_empty, "queue underflow")
    `HCCL_ASSERT_NEXT(a_clear_blocks_pop, clear_busy, !q_pop, "queue popped during clear")

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import hccl_pkg::*;

    // Must match the DUT parameters below.
    localparam int MAX_CACHE_BITS   = 10;
    localparam int MAX_BLOCKS       = 16;
    localparam int MAX_WIDTH        = 4096;
    localparam int BLOCK_BITS       = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int STORE_DEPTH      = MAX_BLOCKS << MAX_CACHE_BITS;
    localparam int SLOT_DEPTH       = 1 << MAX_CACHE_BITS;

    localparam int IDLE_PCT         = 34;   // idle / stall chance per cycle, in percent
    localparam int SETTLE_CYCLES    = 8;    // margin after the last expected result word
    localparam int RANDOM_IMAGES    = 10;
    localparam int WORDS_PER_IMAGE  = 110;
    localparam int MAX_EXTRA_STARTS = 4;    // each start runs a full clearing pass
    localparam int CALM_IMAGE       = 3;    // random image run with no idling at all
    localparam int MAX_REPORTS      = 10;
    // Slowest run: ~16 image starts, each with a full clearing pass, plus ~1.1k pixel words.
    // That is about 1.2 ms. The limit below allows about five times that.
    localparam int RUN_LIMIT_NS     = 6_000_000;

    // Unused register index; a write to it must change nothing.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic                      hit;
        logic [MAX_CACHE_BITS-1:0] slot;
        logic [BLOCK_BITS-1:0]     blk;
        logic [31:0]               total;
        logic [31:0]               count;
    } lookup_result_t;

    // ------------------------------------------------------------------
    // DUT signals. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic                      clk              = 1'b0;
    logic                      rst_n            = 1'b0;
    logic                      cfg_write_enable = 1'b0;
    logic [CFG_INDEX_W-1:0]    cfg_index        = '0;
    logic [CFG_DATA_W-1:0]     cfg_data         = '0;
    logic                      in_valid         = 1'b0;
    logic                      in_stall;
    logic [7:0]                red              = '0;
    logic [7:0]                green            = '0;
    logic [7:0]                blue             = '0;
    logic [7:0]                alpha            = '0;
    logic                      start_of_image   = 1'b0;
    logic                      out_valid;
    logic                      out_stall        = 1'b0;
    logic                      hit;
    logic [MAX_CACHE_BITS-1:0] slot_index;
    logic [BLOCK_BITS-1:0]     block_number;
    logic [31:0]               hits_total;
    logic [31:0]               slot_hit_count;

    // While set, neither side idles.
    logic                      calm             = 1'b0;

    hashed_colour_cache_lookup #(
        .MAX_CACHE_BITS (MAX_CACHE_BITS),
        .MAX_BLOCKS     (MAX_BLOCKS),
        .MAX_WIDTH      (MAX_WIDTH)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .red              (red),
        .green            (green),
        .blue             (blue),
        .alpha            (alpha),
        .start_of_image   (start_of_image),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .hit              (hit),
        .slot_index       (slot_index),
        .block_number     (block_number),
        .hits_total       (hits_total),
        .slot_hit_count   (slot_hit_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Cache predictor: the TB's own copy of registers and stores.
    // ------------------------------------------------------------------
    logic [CACHE_BITS_W-1:0] cfg_cache_bits  = RESET_CACHE_BITS;
    logic [BLOCK_W_W-1:0]    cfg_block_width = RESET_BLOCK_WIDTH;
    logic [IMAGE_W_W-1:0]    cfg_image_width = RESET_IMAGE_WIDTH;

    logic [31:0] colour_mem [STORE_DEPTH];   // entry = block << MAX_CACHE_BITS | slot
    logic [31:0] slot_hits  [SLOT_DEPTH];    // shared by all blocks
    logic [31:0] total_hits;
    int unsigned col_pos;
    int unsigned blk_pos;
    int unsigned col_in_blk;

    lookup_result_t pending_results [$];
    int unsigned    mismatches = 0;

    // Cache bits are clamped to 1..MAX_CACHE_BITS.
    function automatic int unsigned eff_cache_bits();
        if (cfg_cache_bits == 0)
            return 1;
        if (cfg_cache_bits > MAX_CACHE_BITS)
            return MAX_CACHE_BITS;
        return 32'(cfg_cache_bits);
    endfunction

    // Image width is clamped to 1..MAX_WIDTH.
    function automatic int unsigned eff_image_width();
        if (cfg_image_width == 0)
            return 1;
        if (cfg_image_width > MAX_WIDTH)
            return MAX_WIDTH;
        return 32'(cfg_image_width);
    endfunction

    // A block width of zero means one block spans the whole row.
    function automatic int unsigned eff_block_width();
        return (cfg_block_width == 0) ? eff_image_width() : 32'(cfg_block_width);
    endfunction

    // The slot is the top cache bits of the low 32 bits of the product.
    function automatic int unsigned slot_of(input logic [31:0] colour);
        logic [31:0] prod;
        prod = colour * HASH_MUL;
        return prod >> (32 - eff_cache_bits());
    endfunction

    function automatic int unsigned mem_addr(input int unsigned blk, input int unsigned slot);
        return ((blk % MAX_BLOCKS) << MAX_CACHE_BITS) | (slot & (SLOT_DEPTH - 1));
    endfunction

    // Start of image: wipe everything, then preload the default colours into every block.
    function automatic void clear_colour_caches();
        foreach (colour_mem[i])
            colour_mem[i] = '0;
        foreach (slot_hits[i])
            slot_hits[i] = '0;
        total_hits = '0;
        col_pos    = 0;
        blk_pos    = 0;
        col_in_blk = 0;
        for (int b = 0; b < MAX_BLOCKS; b++)
            for (int i = 0; i < NUM_PRELOAD; i++)
                colour_mem[mem_addr(b, slot_of(PRELOAD_COLOURS[i]))] = PRELOAD_COLOURS[i];
    endfunction

    // One pixel through the cache, then advance the column and block trackers.
    function automatic lookup_result_t lookup_pixel(input logic [31:0] px, input logic sof);
        lookup_result_t r;
        int unsigned    slot;
        int unsigned    addr;
        if (sof)
            clear_colour_caches();
        slot  = slot_of(px);
        addr  = mem_addr(blk_pos, slot);
        r.hit = (colour_mem[addr] == px);
        if (r.hit)
        begin
            if (total_hits != '1)
                total_hits++;
            if (slot_hits[slot] != '1)
                slot_hits[slot]++;
        end
        else
        begin
            colour_mem[addr] = px;
        end
        r.slot  = MAX_CACHE_BITS'(slot);
        r.blk   = BLOCK_BITS'(blk_pos);
        r.total = total_hits;
        r.count = slot_hits[slot];

        col_pos++;
        col_in_blk++;
        // If the width shrank mid-row, a column at or past it wraps here.
        if (col_pos >= eff_image_width())
        begin
            col_pos    = 0;
            col_in_blk = 0;
            blk_pos    = 0;
        end
        else if (col_in_blk >= eff_block_width())
        begin
            col_in_blk = 0;
            // Columns past the last block stay in the last block.
            if (blk_pos < MAX_BLOCKS - 1)
                blk_pos++;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers. Everything is driven with NBAs at a rising edge.
    // Handshakes are sampled on the falling edge, where all signals are settled.
    // ------------------------------------------------------------------

    // Register write. The leading edge keeps the enable from being lowered and raised
    // in the same step when two writes follow each other.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_write_enable <= 1'b1;
        cfg_index        <= idx;
        cfg_data         <= value;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        case (idx)
            CFG_CACHE_BITS:  cfg_cache_bits  = value[CACHE_BITS_W-1:0];
            CFG_BLOCK_WIDTH: cfg_block_width = value[BLOCK_W_W-1:0];
            CFG_IMAGE_WIDTH: cfg_image_width = value[IMAGE_W_W-1:0];
            default: ;
        endcase
    endtask

    // Send one pixel word. Call this at a rising edge. It returns at the edge where the
    // word is accepted, with valid still high, so the next word can follow at once.
    task automatic send_pixel(input logic [31:0] px, input logic sof);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        red            <= px[31:24];
        green          <= px[23:16];
        blue           <= px[15:8];
        alpha          <= px[7:0];
        start_of_image <= sof;
        do
            @(negedge clk);
        while (in_stall);
        @(posedge clk);
        pending_results.push_back(lookup_pixel(px, sof));
    endtask

    // Idle the input and wait until every expected result word has arrived.
    // The block is then idle, so register writes are safe.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random back-pressure on the result channel.
    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);

    // Result checker: a word is taken at the edge after a low-stall, high-valid sample.
    always @(negedge clk)
    begin
        lookup_result_t got;
        lookup_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{hit, slot_index, block_number, hits_total, slot_hit_count};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result word with nothing expected: hit=%0d slot=%0d blk=%0d",
                             $realtime, got.hit, got.slot, got.blk);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.hit !== want.hit || got.slot !== want.slot || got.blk !== want.blk
                    || got.total !== want.total || got.count !== want.count)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("%0t: mismatch, expected hit=%0d slot=%0d blk=%0d total=%0h cnt=%0h",
                                 $realtime, want.hit, want.slot, want.blk, want.total,
                                 want.count);
                        $display("%0t:                got hit=%0d slot=%0d blk=%0d total=%0h cnt=%0h",
                                 $realtime, got.hit, got.slot, got.blk, got.total, got.count);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset registers: preloaded default colours hit in block 0. All-zero pixels also hit
    // on a zeroed slot.
    task automatic test_default_colours();
        send_pixel(PRELOAD_COLOURS[0], 1'b0);
        send_pixel(PRELOAD_COLOURS[1], 1'b0);
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'h0000_0000, 1'b0);
        drain_results();
    endtask

    // Zero cache bits act as 1. Zero block and image widths, plus masked high data bits.
    // Old entries are read under the new hash width until a start clears them.
    task automatic test_out_of_range_registers();
        write_reg(CFG_CACHE_BITS, 13'h1FF0);
        write_reg(CFG_BLOCK_WIDTH, 13'h0000);
        write_reg(CFG_IMAGE_WIDTH, 13'h0000);
        write_reg(CFG_UNUSED, 13'h1FFF);
        send_pixel(PRELOAD_COLOURS[0], 1'b0);
        send_pixel(PRELOAD_COLOURS[0], 1'b0);
        send_pixel(PRELOAD_COLOURS[5], 1'b1);       // start, preload with 2 slots
        send_pixel(32'hFFFF_FFFF, 1'b0);
        drain_results();
    endtask

    // One column per block over a capped-width row: blocks 0..15, then stuck at the last.
    // Cache bits above the maximum act as the maximum.
    task automatic test_block_clamp();
        write_reg(CFG_CACHE_BITS, 13'h000F);
        write_reg(CFG_BLOCK_WIDTH, 13'd1);
        write_reg(CFG_IMAGE_WIDTH, 13'h1FFF);
        calm <= 1'b1;
        for (int n = 0; n < MAX_BLOCKS + 1; n++)
            send_pixel(PRELOAD_COLOURS[6], 1'b0);
        drain_results();
        calm <= 1'b0;
    endtask

    // Row shrinks under the current column: that pixel still uses its block, then wraps.
    task automatic test_width_change_mid_row();
        write_reg(CFG_IMAGE_WIDTH, 13'd4);
        write_reg(CFG_BLOCK_WIDTH, 13'h1FFF);
        for (int n = 0; n < 3; n++)
            send_pixel(PRELOAD_COLOURS[6], 1'b0);
        drain_results();
    endtask

    // Random images. Most start with a start word. Pixels come mostly from a small
    // palette so that hits pile up, mixed with fresh colours, defaults and repeats.
    task automatic test_random_images();
        logic [31:0]               palette [12];
        int unsigned               palette_size;
        int unsigned               spare_starts;
        logic [31:0]               colour;
        logic                      sof;
        logic [CACHE_BITS_W-1:0]   cbits;
        logic [CFG_DATA_W-1:0]     bwidth;
        logic [CFG_DATA_W-1:0]     iwidth;
        spare_starts = MAX_EXTRA_STARTS;
        for (int img = 0; img < RANDOM_IMAGES; img++)
        begin
            // Small cache sizes often, for many slot collisions.
            cbits = CACHE_BITS_W'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                       : $urandom_range(0, 15));
            case ($urandom_range(0, 2))
                0:       iwidth = CFG_DATA_W'($urandom_range(1, 8));
                1:       iwidth = CFG_DATA_W'($urandom_range(9, 64));
                default: iwidth = CFG_DATA_W'($urandom_range(0, 8191));
            endcase
            case ($urandom_range(0, 3))
                0:       bwidth = '0;
                1:       bwidth = CFG_DATA_W'($urandom_range(1, 4));
                2:       bwidth = CFG_DATA_W'($urandom_range(1, 16));
                default: bwidth = CFG_DATA_W'($urandom_range(0, 8191));
            endcase
            // Junk in the unused high data bits must be dropped.
            write_reg(CFG_CACHE_BITS, {9'($urandom), cbits});
            write_reg(CFG_BLOCK_WIDTH, bwidth);
            write_reg(CFG_IMAGE_WIDTH, iwidth);
            calm <= (img == CALM_IMAGE);

            palette_size = $urandom_range(2, 12);
            for (int i = 0; i < palette_size; i++)
                palette[i] = $urandom;
            colour = palette[0];

            for (int n = 0; n < WORDS_PER_IMAGE; n++)
            begin
                sof = 1'b0;
                if (n == 0)
                begin
                    sof = ($urandom_range(0, 4) != 0);
                end
                else if (spare_starts > 0 && $urandom_range(0, 199) == 0)
                begin
                    sof = 1'b1;       // rare start in the middle of an image
                    spare_starts--;
                end
                case ($urandom_range(0, 9))
                    0, 1:    colour = $urandom;
                    2:       colour = PRELOAD_COLOURS[$urandom_range(0, NUM_PRELOAD - 1)];
                    3:       ;        // same colour again
                    default: colour = palette[$urandom_range(0, palette_size - 1)];
                endcase
                send_pixel(colour, sof);
            end
            drain_results();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        clear_colour_caches();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        // Pixel words wait out the clearing pass through the handshake.
        test_default_colours();
        test_out_of_range_registers();
        test_block_clamp();
        test_width_change_mid_row();
        test_random_images();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #RUN_LIMIT_NS;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/hccl_pkg.sv
hdl/hccl_fifo.sv
hdl/hccl_front.sv
hdl/hccl_back.sv
hdl/hashed_colour_cache_lookup.sv
tb/testbench.sv
